[design/ksm_pkg.sv]
// Package for the k-smallest tracker: mode codes, cell operation codes,
// the control word broadcast along the cell row, and fixed field widths.
// No dependencies.
package ksm_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;
    localparam int MODE_W  = 2;

    localparam logic signed [VALUE_W-1:0] RESET_VALUE = 32'sh7FFF_FFFF;

    // Input item modes.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

    // Operations applied by every cell in the same cycle.
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_FILL   = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [VALUE_W-1:0] sample;
    } ksm_ctrl_t;

endpackage

[design/k_smallest_tracker.sv]
// Insert and fill words can follow back to back while the output is not stalled;
// the result word appears in the cycle after acceptance, in an output register.
// A dump gives KEEP_COUNT result words, one per cycle while the output is not
// stalled, as the cell row rotates; no input word is taken during the dump.
// Synchronous active-low reset sets every entry to 2147483647 and empties
// the output register.
module k_smallest_tracker
    import ksm_pkg::*;
#(
    parameter int KEEP_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] out_value, [37:32] out_rank, [39:38] zero
    output logic        m_tlast    // last_flag
);

    localparam int CNT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEEP_COUNT - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [RANK_W-1:0] out_rank_reg, out_rank_next;
    logic out_last_reg, out_last_next;

    logic out_free;
    logic accept;
    logic dump_step;
    logic [MODE_W-1:0] mode;
    ksm_ctrl_t ctrl;
    logic signed [VALUE_W-1:0] carry_out;

    logic signed [VALUE_W-1:0] cell_value [KEEP_COUNT];
    logic                      cell_take  [KEEP_COUNT];

    assign mode      = s_tuser;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign dump_step = (state_reg == ST_DUMP) && out_free;

    always_comb begin
        ctrl.sample = s_tdata;
        ctrl.op     = CELL_HOLD;
        if (dump_step) begin
            ctrl.op = CELL_ROTATE;
        end else if (accept) begin
            case (mode)
                MODE_INSERT: ctrl.op = CELL_INSERT;
                MODE_FILL:   ctrl.op = CELL_FILL;
                default:     ctrl.op = CELL_HOLD;
            endcase
        end
    end

    generate
        for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
            logic signed [VALUE_W-1:0] left_v;
            logic                      left_t;
            logic signed [VALUE_W-1:0] right_v;

            if (i == 0) begin : g_head
                assign left_v = $signed(s_tdata);
                assign left_t = 1'b0;
            end else begin : g_body
                assign left_v = cell_value[i-1];
                assign left_t = cell_take[i-1];
            end

            // During a dump the row rotates toward rank zero; the head wraps
            // around to the tail so the list is restored after a full pass.
            if (i == KEEP_COUNT - 1) begin : g_tail
                assign right_v = cell_value[0];
            end else begin : g_mid
                assign right_v = cell_value[i+1];
            end

            ksm_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .left_value  (left_v),
                .left_take   (left_t),
                .right_value (right_v),
                .value       (cell_value[i]),
                .take        (cell_take[i])
            );
        end
    endgenerate

    assign carry_out = cell_take[KEEP_COUNT-1] ? cell_value[KEEP_COUNT-1] : $signed(s_tdata);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_rank_next  = out_rank_reg;
        out_last_next  = out_last_reg;

        if (dump_step) begin
            out_valid_next = 1'b1;
            out_value_next = cell_value[0];
            out_rank_next  = RANK_W'(cnt_reg);
            out_last_next  = (cnt_reg == CNT_LAST);
            cnt_next       = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                state_next = ST_IDLE;
            end
        end else if (accept) begin
            case (mode)
                MODE_INSERT: begin
                    out_valid_next = 1'b1;
                    out_value_next = carry_out;
                    out_rank_next  = '0;
                    out_last_next  = 1'b1;
                end
                MODE_FILL: begin
                    out_valid_next = 1'b1;
                    out_value_next = $signed(s_tdata);
                    out_rank_next  = '0;
                    out_last_next  = 1'b1;
                end
                MODE_DUMP: begin
                    state_next = ST_DUMP;
                    cnt_next   = '0;
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
        out_rank_reg  <= out_rank_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_rank_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

    a_no_input_in_dump : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> !s_tready)
        else $error("input word accepted during dump");

    a_dump_starts : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (mode == MODE_DUMP)) |=> (state_reg == ST_DUMP) && (cnt_reg == '0))
        else $error("dump did not start after dump word");

    a_dump_last_rank : assert property (@(posedge aclk) disable iff (!aresetn)
        dump_step |=> m_tvalid && (m_tlast == (out_rank_reg == RANK_W'(KEEP_COUNT - 1))))
        else $error("dump last flag does not match final rank");

    generate
        for (genvar j = 0; j + 1 < KEEP_COUNT; j++) begin : g_order_chk
            a_sorted : assert property (@(posedge aclk) disable iff (!aresetn)
                (state_reg == ST_IDLE) |-> (cell_value[j] <= cell_value[j+1]))
                else $error("kept list out of order");
        end
    endgenerate

endmodule

[design/ksm_cell.sv]
// One entry of the sorted list: holds a value, compares it with the
// broadcast sample and takes the sample or its left or right neighbor's value.
// Depends on ksm_pkg.
module ksm_cell
    import ksm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ksm_ctrl_t                 ctrl,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic                      left_take,
    input  logic signed [VALUE_W-1:0] right_value,
    output logic signed [VALUE_W-1:0] value,
    output logic                      take
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // Strictly smaller, so a sample equal to this entry lands after it.
    assign take  = $signed(ctrl.sample) < value_reg;
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (take) begin
                    value_next = left_take ? left_value : $signed(ctrl.sample);
                end
            end
            CELL_FILL: begin
                value_next = $signed(ctrl.sample);
            end
            CELL_ROTATE: begin
                value_next = right_value;
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= RESET_VALUE;
        end else begin
            value_reg <= value_next;
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for k_smallest_tracker: a directed table, then random
// words under several idling phases, all checked against an in-bench model.
// Depends on ksm_pkg and the k_smallest_tracker RTL only.
module tb_top
    import ksm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEEP          = 8;
    localparam int RAND_PER_PH   = 37;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int MAX_REPORTS   = 40;

    localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] V_MAX       = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] V_MIN       = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] V_NEG1      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RANK_W-1:0]  rank;
        logic               last;
    } out_word_t;

    // fixed = 1: every result of the row carries the typed-in value.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] val;
        logic               fixed;
        logic [VALUE_W-1:0] want;
    } stim_row_t;

    localparam int DIR_ROWS = 24;
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{MODE_DUMP,   32'd0,         1'b1, V_MAX},
        '{MODE_INSERT, V_MAX,         1'b1, V_MAX},
        '{MODE_INSERT, V_MIN,         1'b1, V_MAX},
        '{MODE_INSERT, 32'd0,         1'b1, V_MAX},
        '{MODE_INSERT, V_NEG1,        1'b1, V_MAX},
        '{MODE_INSERT, 32'd0,         1'b1, V_MAX},
        '{MODE_DUMP,   V_NEG1,        1'b0, 32'd0},
        '{MODE_UNUSED, V_NEG1,        1'b0, 32'd0},
        '{MODE_FILL,   V_MIN,         1'b1, V_MIN},
        '{MODE_INSERT, V_MAX,         1'b1, V_MAX},
        '{MODE_INSERT, V_MIN,         1'b1, V_MIN},
        '{MODE_DUMP,   32'd0,         1'b1, V_MIN},
        '{MODE_FILL,   32'd5,         1'b1, 32'd5},
        '{MODE_INSERT, 32'd3,         1'b0, 32'd0},
        '{MODE_INSERT, 32'd7,         1'b0, 32'd0},
        '{MODE_INSERT, 32'd5,         1'b0, 32'd0},
        '{MODE_INSERT, 32'hFFFF_FFF9, 1'b0, 32'd0},
        '{MODE_INSERT, 32'h5555_5555, 1'b0, 32'd0},
        '{MODE_INSERT, 32'hAAAA_AAAA, 1'b0, 32'd0},
        '{MODE_UNUSED, 32'd0,         1'b0, 32'd0},
        '{MODE_DUMP,   32'd0,         1'b0, 32'd0},
        '{MODE_FILL,   V_MAX,         1'b1, V_MAX},
        '{MODE_INSERT, 32'd1,         1'b0, 32'd0},
        '{MODE_DUMP,   32'd0,         1'b0, 32'd0}
    };

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;
    logic [1:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [39:0]        m_tdata;
    logic               m_tlast;

    logic signed [VALUE_W-1:0] kept [KEEP];
    out_word_t                 expected_words [$];
    int                        errors        = 0;
    int                        cycles        = 0;
    int                        send_idle_pct = 0;
    int                        stall_pct     = 0;

    k_smallest_tracker #(.KEEP_COUNT(KEEP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Updates the kept list for one accepted word and queues the words it
    // should produce.
    task automatic track_word(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] val);
        logic signed [VALUE_W-1:0] carry;
        logic signed [VALUE_W-1:0] tmp;
        case (mode)
            MODE_INSERT: begin
                carry = val;
                // Strict compare: an equal sample lands after the kept copy.
                for (int i = 0; i < KEEP; i++) begin
                    if (carry < kept[i]) begin
                        tmp     = kept[i];
                        kept[i] = carry;
                        carry   = tmp;
                    end
                end
                expected_words.push_back('{carry, '0, 1'b1});
            end
            MODE_FILL: begin
                for (int i = 0; i < KEEP; i++) kept[i] = val;
                expected_words.push_back('{val, '0, 1'b1});
            end
            MODE_DUMP: begin
                for (int i = 0; i < KEEP; i++)
                    expected_words.push_back('{kept[i], RANK_W'(i), i == KEEP - 1});
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] val,
                             input logic fixed, input logic [VALUE_W-1:0] want);
        int n0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        n0 = expected_words.size();
        track_word(mode, val);
        if (fixed) begin
            for (int k = n0; k < expected_words.size(); k++) expected_words[k].value = want;
        end
    endtask

    // Corner values, small values near zero, values that collide with or sit near the kept list, and random words.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return V_MIN;
                    1:       return V_MAX;
                    2:       return V_NEG1;
                    default: return 32'd0;
                endcase
            end
            1, 2, 3: return VALUE_W'($signed($urandom_range(0, 40)) - 20);
            4, 5:    return VALUE_W'(kept[$urandom_range(0, KEEP - 1)]
                                     + $signed($urandom_range(0, 4)) - 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic report(input string field, input logic [VALUE_W-1:0] want,
                          input logic [VALUE_W-1:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin : result_check
        out_word_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", '0, m_tdata[31:0]);
            end else begin
                w = expected_words.pop_front();
                if (m_tdata[31:0] !== w.value)
                    report("out_value", w.value, m_tdata[31:0]);
                if (m_tdata[37:32] !== w.rank)
                    report("out_rank", VALUE_W'(w.rank), VALUE_W'(m_tdata[37:32]));
                if (m_tlast !== w.last)
                    report("last_flag", VALUE_W'(w.last), VALUE_W'(m_tlast));
                if (m_tdata[39:38] !== 2'b00)
                    report("tdata padding", '0, VALUE_W'(m_tdata[39:38]));
            end
        end
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** k_smallest_tracker: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int                 r;
        logic [MODE_W-1:0]  m;
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < KEEP; i++) kept[i] = RESET_VALUE;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].mode, dir_rows[i].val, dir_rows[i].fixed, dir_rows[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            // Hold the input off until every pending word has drained.
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (expected_words.size() != 0);
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 59; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            for (int n = 0; n < RAND_PER_PH; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    m = MODE_FILL;
                    v = ($urandom_range(0, 1) == 0) ? V_MAX : pick_value();
                end else if (r < 16) begin
                    m = MODE_DUMP;
                    v = $urandom;
                end else if (r < 20) begin
                    m = MODE_UNUSED;
                    v = $urandom;
                end else begin
                    m = MODE_INSERT;
                    v = pick_value();
                end
                send_word(m, v, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_words.size() != 0);
        repeat (KEEP + 4) @(posedge aclk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("** k_smallest_tracker: PASSED **");
        end else begin
            $display("** k_smallest_tracker: FAILED **");
        end
        $finish;
    end

endmodule
